### src/psod_pkg.sv
// Package for the pose send-on-delta filter: table size, item codes and types.
// Used by the filter top level.
`default_nettype none

package psod_pkg;

    // Size of the pose table.
    localparam int MAX_BODIES = 64;
    localparam int SLOT_AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

    // Fixed-point one in Q2.30.
    localparam logic [38:0] ONE_Q30 = 39'd1 << 30;

    // Input item modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_POSE  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    // Result item kinds.
    localparam logic KIND_POSE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_POS_THR     = 2'd0;
    localparam logic [1:0] REG_ORI_THR     = 2'd1;
    localparam logic [1:0] REG_REFRESH     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] POS_THR_RESET = 16'd33;
    localparam logic [29:0] ORI_THR_RESET = 30'd10737;
    localparam logic [31:0] REFRESH_RESET = 32'd500000;

    typedef logic [SLOT_AW-1:0] slot_idx_t;

    // One stored or emitted pose.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } pose_t;

    // One result item as held in the output stage.
    typedef struct packed {
        logic       kind;
        logic [5:0] slot;
        pose_t      pose;
        logic       frame_sent;
    } out_item_t;

    // True for a pose item whose slot lies inside the table.
    function automatic logic is_table_pose(input logic [1:0] mode, input logic [5:0] slot);
        is_table_pose = (mode == MODE_POSE) && (32'(slot) < MAX_BODIES);
    endfunction

endpackage

`default_nettype wire

### src/psod_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Stand-alone; field widths follow the item definitions of the filter.
`default_nettype none

interface psod_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [5:0]         body_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic [31:0]        frame_time;
    logic [15:0]        subscriber_count;

    modport source (
        output valid, mode, body_slot, pos_x, pos_y, pos_z,
               quat_w, quat_x, quat_y, quat_z, frame_time, subscriber_count,
        input  ready
    );
    modport sink (
        input  valid, mode, body_slot, pos_x, pos_y, pos_z,
               quat_w, quat_x, quat_y, quat_z, frame_time, subscriber_count,
        output ready
    );
endinterface

interface psod_out_if;
    logic               valid;
    logic               ready;
    logic               out_kind;
    logic [5:0]         out_slot;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_quat_w;
    logic signed [31:0] out_quat_x;
    logic signed [31:0] out_quat_y;
    logic signed [31:0] out_quat_z;
    logic               frame_sent;

    modport source (
        output valid, out_kind, out_slot, out_pos_x, out_pos_y, out_pos_z,
               out_quat_w, out_quat_x, out_quat_y, out_quat_z, frame_sent,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_slot, out_pos_x, out_pos_y, out_pos_z,
               out_quat_w, out_quat_x, out_quat_y, out_quat_z, frame_sent,
        output ready
    );
endinterface

`default_nettype wire

### src/pose_send_on_delta_filter_top.sv
// Top level of the pose send-on-delta filter: pipeline, pose table and APB registers.
// Depends on psod_pkg, the psod_in_if / psod_out_if interfaces and psod_ram.
`default_nettype none

// The filter takes one item per clock cycle while the skid register is empty and no
// table hazard holds stage 1, and passes its result, if any, through stages 1 to 3 into
// a two-entry output stage, so the input keeps flowing while a result waits to be taken.
// The last pose sent for each slot lives in one table RAM that is read when the item
// is accepted and written back from stage 3; of two pose items for the same slot back
// to back, the second waits in stage 1 for the first one's write-back. The table
// starts as all zeros after reset through per-slot valid flags, with no clearing pass.
// Thresholds and the refresh interval are written over APB at byte addresses 0, 4 and
// 8; the user must do so only while no item is in flight, the block does not enforce it.
module pose_send_on_delta_filter_top
    import psod_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    psod_in_if.sink          item_in,
    psod_out_if.source       result_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Configuration registers.
    logic [15:0] pos_thr_reg;
    logic [29:0] ori_thr_reg;
    logic [31:0] refresh_reg;

    // Frame state.
    logic        ever_sent_reg;
    logic [31:0] last_full_time_reg;
    logic [15:0] last_subs_reg;
    logic        frame_full_reg;
    logic        frame_any_reg;

    // Stage 1: accepted item, table read in flight.
    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [5:0]  s1_slot_reg;
    pose_t       s1_pose_reg;
    logic [31:0] s1_time_reg;
    logic [15:0] s1_subs_reg;

    // Stage 2: item with the last sent pose of its slot.
    logic        s2_valid_reg;
    logic [1:0]  s2_mode_reg;
    logic [5:0]  s2_slot_reg;
    pose_t       s2_pose_reg;
    pose_t       s2_old_reg;
    logic [31:0] s2_time_reg;
    logic [15:0] s2_subs_reg;

    // Stage 3: position test result and quaternion products.
    logic               s3_valid_reg;
    logic [1:0]         s3_mode_reg;
    logic [5:0]         s3_slot_reg;
    pose_t              s3_pose_reg;
    logic [31:0]        s3_time_reg;
    logic [15:0]        s3_subs_reg;
    logic               s3_pos_moved_reg;
    logic signed [63:0] s3_prod_reg [4];

    // Pose table bookkeeping.
    logic [MAX_BODIES-1:0] slot_valid_reg;
    logic                  byp_valid_reg;
    pose_t                 byp_data_reg;

    // Output stage: main register and skid register.
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;

    // Pipeline control.
    logic      advance;
    logic      hazard;
    logic      s1_move;
    logic      accept;
    logic      pop;
    logic      push;
    out_item_t push_data;

    // Table ports.
    logic      ram_we;
    slot_idx_t ram_waddr;
    slot_idx_t ram_raddr;
    pose_t     ram_rdata;
    slot_idx_t s1_idx;
    logic      fwd_now;
    pose_t     s1_old;

    // Stage 2 arithmetic.
    logic signed [32:0] diff_x;
    logic signed [32:0] diff_y;
    logic signed [32:0] diff_z;
    logic [32:0]        mag_x;
    logic [32:0]        mag_y;
    logic [32:0]        mag_z;
    logic               pos_moved;
    logic signed [63:0] prod [4];

    // Stage 3 arithmetic.
    logic signed [33:0] term [4];
    logic signed [35:0] dot;
    logic [35:0]        dot_mag;
    logic               ori_moved;
    logic               s3_is_pose;
    logic               moved;
    logic [31:0]        elapsed;
    logic               start_full;
    logic               cfg_write;

    // The whole pipeline moves unless the skid register is occupied; stage 1 also holds on a hazard.
    assign advance = !skid_valid_reg;

    // A pose right behind a pose of the same slot waits for its write-back.
    assign hazard = s1_valid_reg && s2_valid_reg
                    && is_table_pose(s1_mode_reg, s1_slot_reg)
                    && is_table_pose(s2_mode_reg, s2_slot_reg)
                    && (s1_slot_reg == s2_slot_reg);

    assign s1_move       = advance && !hazard;
    assign item_in.ready = s1_move;
    assign accept        = item_in.valid && s1_move;

    // Stage 1 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg        <= item_in.mode;
            s1_slot_reg        <= item_in.body_slot;
            s1_pose_reg.pos_x  <= item_in.pos_x;
            s1_pose_reg.pos_y  <= item_in.pos_y;
            s1_pose_reg.pos_z  <= item_in.pos_z;
            s1_pose_reg.quat_w <= item_in.quat_w;
            s1_pose_reg.quat_x <= item_in.quat_x;
            s1_pose_reg.quat_y <= item_in.quat_y;
            s1_pose_reg.quat_z <= item_in.quat_z;
            s1_time_reg        <= item_in.frame_time;
            s1_subs_reg        <= item_in.subscriber_count;
        end
    end

    // Table read follows the item that will sit in stage 1 next cycle.
    assign s1_idx    = slot_idx_t'(s1_slot_reg);
    assign ram_raddr = accept ? slot_idx_t'(item_in.body_slot) : s1_idx;
    assign ram_waddr = slot_idx_t'(s3_slot_reg);

    psod_ram #(
        .WIDTH ($bits(pose_t)),
        .DEPTH (MAX_BODIES)
    ) u_pose_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s3_pose_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Last sent pose: a write in this cycle, then a write that collided with the
    // read, then the table itself, where a never-written slot reads as zero.
    assign fwd_now = ram_we && (ram_waddr == s1_idx);

    always_comb
    begin
        if (fwd_now)
        begin
            s1_old = s3_pose_reg;
        end
        else if (byp_valid_reg)
        begin
            s1_old = byp_data_reg;
        end
        else if (slot_valid_reg[s1_idx])
        begin
            s1_old = ram_rdata;
        end
        else
        begin
            s1_old = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            byp_valid_reg <= ram_we && (ram_waddr == ram_raddr);
            if (ram_we)
            begin
                slot_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= s3_pose_reg;
    end

    // Stage 2 register; a bubble enters while the hazard holds stage 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && !hazard;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_pose_reg <= s1_pose_reg;
            s2_old_reg  <= s1_old;
            s2_time_reg <= s1_time_reg;
            s2_subs_reg <= s1_subs_reg;
        end
    end

    // Per-axis position change against the threshold.
    assign diff_x = {s2_pose_reg.pos_x[31], s2_pose_reg.pos_x}
                    - {s2_old_reg.pos_x[31], s2_old_reg.pos_x};
    assign diff_y = {s2_pose_reg.pos_y[31], s2_pose_reg.pos_y}
                    - {s2_old_reg.pos_y[31], s2_old_reg.pos_y};
    assign diff_z = {s2_pose_reg.pos_z[31], s2_pose_reg.pos_z}
                    - {s2_old_reg.pos_z[31], s2_old_reg.pos_z};
    assign mag_x  = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
    assign mag_y  = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
    assign mag_z  = diff_z[32] ? 33'(-diff_z) : 33'(diff_z);
    assign pos_moved = (mag_x > {17'd0, pos_thr_reg})
                       || (mag_y > {17'd0, pos_thr_reg})
                       || (mag_z > {17'd0, pos_thr_reg});

    // Quaternion component products, Q4.60.
    assign prod[0] = s2_pose_reg.quat_w * s2_old_reg.quat_w;
    assign prod[1] = s2_pose_reg.quat_x * s2_old_reg.quat_x;
    assign prod[2] = s2_pose_reg.quat_y * s2_old_reg.quat_y;
    assign prod[3] = s2_pose_reg.quat_z * s2_old_reg.quat_z;

    // Stage 3 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_mode_reg      <= s2_mode_reg;
            s3_slot_reg      <= s2_slot_reg;
            s3_pose_reg      <= s2_pose_reg;
            s3_time_reg      <= s2_time_reg;
            s3_subs_reg      <= s2_subs_reg;
            s3_pos_moved_reg <= pos_moved;
            for (int i = 0; i < 4; i++)
            begin
                s3_prod_reg[i] <= prod[i];
            end
        end
    end

    // Dot product: each product floored to Q4.30, then summed exactly.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            term[i] = s3_prod_reg[i][63:30];
        end
    end

    assign dot     = 36'(term[0]) + 36'(term[1]) + 36'(term[2]) + 36'(term[3]);
    assign dot_mag = dot[35] ? 36'(-dot) : 36'(dot);

    // 1 - |dot| > threshold, rearranged as |dot| + threshold < 1.
    assign ori_moved = (39'(dot_mag) + 39'(ori_thr_reg)) < ONE_Q30;

    assign s3_is_pose = s3_valid_reg && is_table_pose(s3_mode_reg, s3_slot_reg);
    assign moved      = frame_full_reg || s3_pos_moved_reg || ori_moved;
    assign ram_we     = advance && s3_is_pose && moved;

    // Frame start decision.
    assign elapsed    = s3_time_reg - last_full_time_reg;
    assign start_full = !ever_sent_reg || (s3_subs_reg > last_subs_reg)
                        || (elapsed > refresh_reg);

    // Frame state update, in item order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ever_sent_reg      <= 1'b0;
            last_full_time_reg <= '0;
            last_subs_reg      <= '0;
            frame_full_reg     <= 1'b0;
            frame_any_reg      <= 1'b0;
        end
        else if (advance && s3_valid_reg)
        begin
            unique case (s3_mode_reg)
                MODE_START:
                begin
                    frame_full_reg <= start_full;
                    last_subs_reg  <= s3_subs_reg;
                    frame_any_reg  <= 1'b0;
                end
                MODE_POSE:
                begin
                    if (ram_we)
                    begin
                        frame_any_reg <= 1'b1;
                    end
                end
                MODE_END:
                begin
                    if (frame_any_reg)
                    begin
                        ever_sent_reg <= 1'b1;
                        if (frame_full_reg)
                        begin
                            last_full_time_reg <= s3_time_reg;
                        end
                    end
                    frame_full_reg <= 1'b0;
                    frame_any_reg  <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of the item in stage 3.
    assign push = advance && s3_valid_reg && (ram_we || (s3_mode_reg == MODE_END));

    always_comb
    begin
        push_data = '0;
        if (s3_mode_reg == MODE_END)
        begin
            push_data.kind       = KIND_END;
            push_data.frame_sent = frame_any_reg;
        end
        else
        begin
            push_data.kind = KIND_POSE;
            push_data.slot = s3_slot_reg;
            push_data.pose = s3_pose_reg;
        end
    end

    // Output stage with skid register.
    assign pop = out_valid_reg && result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.out_kind   = out_data_reg.kind;
    assign result_out.out_slot   = out_data_reg.slot;
    assign result_out.out_pos_x  = out_data_reg.pose.pos_x;
    assign result_out.out_pos_y  = out_data_reg.pose.pos_y;
    assign result_out.out_pos_z  = out_data_reg.pose.pos_z;
    assign result_out.out_quat_w = out_data_reg.pose.quat_w;
    assign result_out.out_quat_x = out_data_reg.pose.quat_x;
    assign result_out.out_quat_y = out_data_reg.pose.quat_y;
    assign result_out.out_quat_z = out_data_reg.pose.quat_z;
    assign result_out.frame_sent = out_data_reg.frame_sent;

    // APB register writes.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_thr_reg <= POS_THR_RESET;
            ori_thr_reg <= ORI_THR_RESET;
            refresh_reg <= REFRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_POS_THR: pos_thr_reg <= pwdata[15:0];
                REG_ORI_THR: ori_thr_reg <= pwdata[29:0];
                REG_REFRESH: refresh_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // APB register reads.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_POS_THR: prdata = {16'd0, pos_thr_reg};
            REG_ORI_THR: prdata = {2'd0, ori_thr_reg};
            REG_REFRESH: prdata = refresh_reg;
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/psod_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module psod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and a read port that returns the old contents on a collision.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
